// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/tpms_pkg.sv =====
`timescale 1ns / 1ps
package tpms_pkg;

   localparam int IDX_W    = 8;
   localparam int FRAC_MAX = 24;
   localparam int VAL_W    = 48;

   typedef enum logic [1:0] {
      K_CLEAR   = 2'd0,
      K_DEPOSIT = 2'd1,
      K_READ    = 2'd2,
      K_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEARED   = 2'd0,
      ST_DEPOSITED = 2'd1,
      ST_SKIPPED   = 2'd2,
      ST_READ      = 2'd3
   } status_type;

   localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z    = 3'd2;
   localparam logic [2:0] REG_INV_SPACING = 3'd3;
   localparam logic [2:0] REG_MARGIN_X    = 3'd4;
   localparam logic [2:0] REG_MARGIN_Y    = 3'd5;
   localparam logic [2:0] REG_MARGIN_Z    = 3'd6;

   typedef enum logic [2:0] {
      F_IDLE, F_SUB, F_MUL, F_EVAL, F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_CLR, B_RD0, B_RD1, B_W1, B_W2, B_SH, B_WR, B_DONE
   } back_state_type;

   typedef struct packed {
      kind_type             kind;
      logic                 ok;
      logic [IDX_W-1:0]     ix;
      logic [IDX_W-1:0]     iy;
      logic [IDX_W-1:0]     iz;
      logic [FRAC_MAX-1:0]  tx;
      logic [FRAC_MAX-1:0]  ty;
      logic [FRAC_MAX-1:0]  tz;
      logic [31:0]          weight;
      logic [14:0]          vidx;
   } cmd_type;

endpackage

// ===== rtl/trilinear_point_mass_splat_top.sv =====
`timescale 1ns / 1ps
// Trilinear point-mass splat: deposits weighted points onto a voxel grid of
// GRID_X*GRID_Y*GRID_Z 48-bit accumulators held in one single-port-write RAM.
// Flow: a deposit passes through the front (accept, then per axis a subtract,
// one 32x32 multiply and an evaluate step, then push) and the back (pop, eight
// corners of a read-modify-write through the RAM port in states B_W1, B_W2,
// B_SH and B_WR, skipped for an out-of-range point, then the result hand-off).
// A read passes B_RD0 and B_RD1 in the back, a clear one cycle per voxel
// (32768 at default size) plus pop and hand-off.
// After reset the block zeroes every RAM word and stalls the request channel
// meanwhile; configuration writes still land.
// A two-entry queue between front and back lets points be converted while
// earlier ones are still being accumulated. Kind 3 is taken and dropped.
module trilinear_point_mass_splat_top #(
   parameter int GRID_X    = 32,
   parameter int GRID_Y    = 32,
   parameter int GRID_Z    = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_kind,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic [31:0]         req_weight,
   input  logic [14:0]         req_voxel_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic signed [47:0]  rsp_voxel_value,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata
);
   import tpms_pkg::*;

   cmd_type push_data, head;
   logic    push, pop, full, empty, init_busy;

   // Front: take the transfer, hold config, convert positions to cells.
   tpms_front #(
      .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_weight(req_weight), .req_voxel_index(req_voxel_index),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .init_busy(init_busy), .q_full(full), .q_push(push), .q_data(push_data)
   );

   // Queue: decouple conversion from accumulation.
   tpms_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data), .full(full),
      .pop(pop), .empty(empty), .head(head)
   );

   // Back: clear sweeps, reads and eight-corner accumulation, output register.
   tpms_back #(
      .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .q_empty(empty), .q_head(head), .q_pop(pop), .init_busy(init_busy),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_voxel_value(rsp_voxel_value)
   );

endmodule

// ===== rtl/tpms_front.sv =====
`timescale 1ns / 1ps
module tpms_front #(
   parameter int GRID_X    = 32,
   parameter int GRID_Y    = 32,
   parameter int GRID_Z    = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_pos_z,
   input  logic [31:0]          req_weight,
   input  logic [14:0]          req_voxel_index,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic                 init_busy,
   input  logic                 q_full,
   output logic                 q_push,
   output tpms_pkg::cmd_type    q_data
);
   import tpms_pkg::*;

   localparam int QW = 64 - 2 * FRAC_BITS;

   front_state_type state_ff, state_in;
   logic [31:0] org_x_ff, org_y_ff, org_z_ff, inv_ff;
   logic [4:0]  mar_x_ff, mar_y_ff, mar_z_ff;
   kind_type    kind_ff;
   logic [31:0] px_ff, py_ff, pz_ff, weight_ff;
   logic [14:0] vidx_ff;
   logic [1:0]  axis_ff;
   logic        neg_ff, ok_ff;
   logic [32:0] mag_ff;
   logic [63:0] prod_ff;
   logic [IDX_W-1:0]    ix_ff, iy_ff, iz_ff;
   logic [FRAC_MAX-1:0] tx_ff, ty_ff, tz_ff;

   logic        accept;
   logic [31:0] pos_sel, org_sel;
   logic [4:0]  mar_sel;
   logic [8:0]  size_sel;
   logic signed [32:0] diff;
   logic [QW-1:0]  q;
   logic [QW:0]    q_ext, q_p1;
   logic [2*FRAC_BITS-1:0] r, r_neg;
   logic [FRAC_BITS-1:0]   frac;
   logic [5:0]  lower;
   logic signed [10:0] upper_s;
   logic        axis_ok;

   assign accept = req_valid && !req_stall;

   always_comb begin
      case (axis_ff)
         2'd0: begin
            pos_sel = px_ff; org_sel = org_x_ff; mar_sel = mar_x_ff; size_sel = 9'(GRID_X);
         end
         2'd1: begin
            pos_sel = py_ff; org_sel = org_y_ff; mar_sel = mar_y_ff; size_sel = 9'(GRID_Y);
         end
         default: begin
            pos_sel = pz_ff; org_sel = org_z_ff; mar_sel = mar_z_ff; size_sel = 9'(GRID_Z);
         end
      endcase
   end

   // Grid units: floor of |d| * inv, fraction mirrored for negative d.
   always_comb begin
      diff    = $signed({pos_sel[31], pos_sel}) - $signed({org_sel[31], org_sel});
      q       = prod_ff[63 -: QW];
      r       = prod_ff[2*FRAC_BITS-1:0];
      r_neg   = (2*FRAC_BITS)'(0) - r;
      frac    = neg_ff ? r_neg[2*FRAC_BITS-1 -: FRAC_BITS] : r[2*FRAC_BITS-1 -: FRAC_BITS];
      lower   = (mar_sel == 5'd0) ? 6'd1 : {1'b0, mar_sel};
      upper_s = $signed({2'b00, size_sel}) - $signed({5'b00000, lower});
      q_ext   = {1'b0, q};
      q_p1    = q_ext + (QW+1)'(1);
      axis_ok = (!neg_ff || prod_ff == 64'd0) && !upper_s[10] &&
                (q_ext < (QW+1)'(upper_s[9:0])) && (q_p1 >= (QW+1)'(lower));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (kind_type'(req_kind) == K_DEPOSIT) state_in = F_SUB;
               else if (kind_type'(req_kind) != K_NONE) state_in = F_PUSH;
            end
         end
         F_SUB:  state_in = F_MUL;
         F_MUL:  state_in = F_EVAL;
         F_EVAL: state_in = (axis_ff == 2'd2) ? F_PUSH : F_SUB;
         F_PUSH: if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != F_IDLE) || init_busy;
      q_push    = (state_ff == F_PUSH) && !q_full;
   end

   assign q_data = '{kind: kind_ff, ok: ok_ff, ix: ix_ff, iy: iy_ff, iz: iz_ff,
                     tx: tx_ff, ty: ty_ff, tz: tz_ff, weight: weight_ff, vidx: vidx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         org_x_ff <= '0; org_y_ff <= '0; org_z_ff <= '0;
         inv_ff   <= 32'(1) << FRAC_BITS;
         mar_x_ff <= '0; mar_y_ff <= '0; mar_z_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               REG_ORIGIN_X:    org_x_ff <= csr_wdata;
               REG_ORIGIN_Y:    org_y_ff <= csr_wdata;
               REG_ORIGIN_Z:    org_z_ff <= csr_wdata;
               REG_INV_SPACING: inv_ff   <= csr_wdata;
               REG_MARGIN_X:    mar_x_ff <= csr_wdata[4:0];
               REG_MARGIN_Y:    mar_y_ff <= csr_wdata[4:0];
               REG_MARGIN_Z:    mar_z_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_type'(req_kind);
         px_ff     <= req_pos_x;
         py_ff     <= req_pos_y;
         pz_ff     <= req_pos_z;
         weight_ff <= req_weight;
         vidx_ff   <= req_voxel_index;
         axis_ff   <= 2'd0;
         ok_ff     <= 1'b1;
      end
      if (state_ff == F_SUB) begin
         neg_ff <= diff[32];
         mag_ff <= diff[32] ? 33'(-diff) : 33'(diff);
      end
      if (state_ff == F_MUL) begin
         // Split the 33-bit magnitude: 32x32 product plus the top bit.
         prod_ff <= 64'(mag_ff[31:0]) * 64'(inv_ff) +
                    (mag_ff[32] ? {inv_ff, 32'd0} : 64'd0);
      end
      if (state_ff == F_EVAL) begin
         ok_ff   <= ok_ff && axis_ok;
         axis_ff <= axis_ff + 2'd1;
         case (axis_ff)
            2'd0: begin ix_ff <= q[IDX_W-1:0]; tx_ff <= FRAC_MAX'(frac); end
            2'd1: begin iy_ff <= q[IDX_W-1:0]; ty_ff <= FRAC_MAX'(frac); end
            default: begin iz_ff <= q[IDX_W-1:0]; tz_ff <= FRAC_MAX'(frac); end
         endcase
      end
   end

endmodule

// ===== rtl/tpms_queue.sv =====
`timescale 1ns / 1ps
module tpms_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tpms_pkg::cmd_type  push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output tpms_pkg::cmd_type  head
);
   import tpms_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== rtl/tpms_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tpms_back #(
   parameter int GRID_X    = 32,
   parameter int GRID_Y    = 32,
   parameter int GRID_Z    = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  tpms_pkg::cmd_type   q_head,
   output logic                q_pop,
   output logic                init_busy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic signed [47:0]  rsp_voxel_value
);
   import tpms_pkg::*;

   localparam int TOTAL = GRID_X * GRID_Y * GRID_Z;
   localparam int AW    = $clog2(TOTAL);
   localparam int WW    = FRAC_BITS + 1;
   localparam logic [VAL_W:0] VAL_MAX = (VAL_W+1)'((64'd1 << 47) - 64'd1);

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;
   logic [2:0]     corner_ff;
   logic [AW-1:0]  clr_addr_ff, addr_ff;
   logic           emit_ff;
   logic [WW-1:0]  wxy_ff, w_ff;
   logic [47:0]    share_ff;
   logic [VAL_W-1:0] rdata_ff, pend_value_ff;
   status_type     pend_status_ff;
   logic           rsp_valid_ff;
   status_type     rsp_status_ff;
   logic [VAL_W-1:0] rsp_value_ff;
   logic [VAL_W-1:0] mem [TOTAL];

   logic            mem_we, mem_re, load_rsp, slot_free, read_in_range;
   logic [AW-1:0]   mem_wa, mem_ra, corner_addr;
   logic [VAL_W-1:0] mem_wd;
   logic [WW-1:0]   one_w, wx, wy, wz;
   logic [2*WW-1:0] wxy_full, w_full;
   logic [31+WW:0]  share_full;
   logic [VAL_W:0]  sum;
   logic [IDX_W:0]  cx, cy, cz;

   assign slot_free     = !rsp_valid_ff || !rsp_stall;
   assign read_in_range = 32'(cmd_ff.vidx) < 32'(TOTAL);

   always_comb begin
      one_w = WW'(1) << FRAC_BITS;
      wx = corner_ff[2] ? WW'(cmd_ff.tx[FRAC_BITS-1:0]) : one_w - WW'(cmd_ff.tx[FRAC_BITS-1:0]);
      wy = corner_ff[1] ? WW'(cmd_ff.ty[FRAC_BITS-1:0]) : one_w - WW'(cmd_ff.ty[FRAC_BITS-1:0]);
      wz = corner_ff[0] ? WW'(cmd_ff.tz[FRAC_BITS-1:0]) : one_w - WW'(cmd_ff.tz[FRAC_BITS-1:0]);
      wxy_full   = (2*WW)'(wx) * (2*WW)'(wy);
      w_full     = (2*WW)'(wxy_ff) * (2*WW)'(wz);
      share_full = (32+WW)'(cmd_ff.weight) * (32+WW)'(w_ff);
      cx = {1'b0, cmd_ff.ix} + (IDX_W+1)'(corner_ff[2]);
      cy = {1'b0, cmd_ff.iy} + (IDX_W+1)'(corner_ff[1]);
      cz = {1'b0, cmd_ff.iz} + (IDX_W+1)'(corner_ff[0]);
      corner_addr = AW'(32'(cz) * 32'(GRID_X * GRID_Y) + 32'(cy) * 32'(GRID_X) + 32'(cx));
      sum = {1'b0, rdata_ff} + (VAL_W+1)'(share_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               unique case (q_head.kind)
                  K_CLEAR:   state_in = B_CLR;
                  K_DEPOSIT: state_in = q_head.ok ? B_W1 : B_DONE;
                  K_READ:    state_in = B_RD0;
                  default:   state_in = B_IDLE;
               endcase
            end
         end
         B_CLR:  if (clr_addr_ff == AW'(TOTAL - 1)) state_in = emit_ff ? B_DONE : B_IDLE;
         B_RD0:  state_in = B_RD1;
         B_RD1:  state_in = B_DONE;
         B_W1:   state_in = B_W2;
         B_W2:   state_in = B_SH;
         B_SH:   state_in = B_WR;
         B_WR:   state_in = (corner_ff == 3'd7) ? B_DONE : B_W1;
         B_DONE: if (slot_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = (state_ff == B_IDLE) && !q_empty;
      init_busy = (state_ff == B_CLR) && !emit_ff;
      load_rsp  = (state_ff == B_DONE) && slot_free;
      mem_we    = 1'b0;
      mem_wa    = clr_addr_ff;
      mem_wd    = '0;
      mem_re    = 1'b0;
      mem_ra    = corner_addr;
      unique case (state_ff)
         B_CLR: mem_we = 1'b1;
         B_RD0: begin
            mem_re = 1'b1;
            mem_ra = AW'(cmd_ff.vidx);
         end
         B_W1: mem_re = 1'b1;
         B_WR: begin
            mem_we = 1'b1;
            mem_wa = addr_ff;
            mem_wd = (sum > VAL_MAX) ? VAL_MAX[VAL_W-1:0] : sum[VAL_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rdata_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLR;
         clr_addr_ff  <= '0;
         emit_ff      <= 1'b0;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (q_pop && q_head.kind == K_CLEAR) begin
            emit_ff     <= 1'b1;
            clr_addr_ff <= '0;
         end else if (state_ff == B_CLR) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
         if (q_pop) corner_ff <= '0;
         else if (state_ff == B_WR) corner_ff <= corner_ff + 3'd1;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff         <= q_head;
         pend_value_ff  <= '0;
         pend_status_ff <= (q_head.kind == K_CLEAR) ? ST_CLEARED :
                           (q_head.kind == K_READ)  ? ST_READ :
                           q_head.ok ? ST_DEPOSITED : ST_SKIPPED;
      end
      if (state_ff == B_RD1) pend_value_ff <= read_in_range ? rdata_ff : '0;
      if (state_ff == B_W1) begin
         wxy_ff  <= wxy_full[FRAC_BITS +: WW];
         addr_ff <= corner_addr;
      end
      if (state_ff == B_W2) w_ff <= w_full[FRAC_BITS +: WW];
      if (state_ff == B_SH) share_ff <= 48'(share_full >> FRAC_BITS);
      if (load_rsp) begin
         rsp_status_ff <= pend_status_ff;
         rsp_value_ff  <= pend_value_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_voxel_value = $signed(rsp_value_ff);

   `ASSERT_IMPLIES(a_we_states, clock, reset, mem_we, (state_ff == B_CLR) || (state_ff == B_WR))
   `ASSERT_IMPLIES(a_no_pop_init, clock, reset, init_busy, !q_pop)
   `ASSERT_NEXT(a_last_corner, clock, reset, (state_ff == B_WR) && (corner_ff == 3'd7), state_ff == B_DONE)

endmodule
